>>> src/cau_pkg.sv
// Shared types, operation codes and saturation helpers for the complex arithmetic unit.
package cau_pkg;

    localparam int DATA_W = 32;
    localparam int PROD_W = 64;
    localparam int QUO_W  = 33;
    localparam int DIV_LAT = QUO_W + 1;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_EQ  = 3'd4;
    localparam logic [2:0] OP_INC = 3'd5;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              ovf;
    } sat_t;

    // Per-item control and results that travel beside the divider.
    typedef struct packed {
        logic [2:0]        op;
        logic [DATA_W-1:0] rr;
        logic [DATA_W-1:0] ri;
        logic              eq;
        logic              dz;
        logic              ovf;
        logic              re_neg;
        logic              im_neg;
    } side_t;

    // Sign and magnitude to a saturated 32-bit two's complement value.
    function automatic sat_t sat_mag(input logic neg, input logic [PROD_W-1:0] mag);
        sat_t r;
        if (neg) begin
            if (mag > 64'h0000_0000_8000_0000) begin
                r.ovf   = 1'b1;
                r.value = 32'h8000_0000;
            end else begin
                r.ovf   = 1'b0;
                r.value = 32'(64'd0 - mag);
            end
        end else begin
            if (mag > 64'h0000_0000_7FFF_FFFF) begin
                r.ovf   = 1'b1;
                r.value = 32'h7FFF_FFFF;
            end else begin
                r.ovf   = 1'b0;
                r.value = mag[DATA_W-1:0];
            end
        end
        return r;
    endfunction

    function automatic sat_t sat_signed(input logic signed [DATA_W:0] v);
        logic [DATA_W:0] abs_v;
        abs_v = v[DATA_W] ? ((DATA_W+1)'(0) - (DATA_W+1)'(v)) : (DATA_W+1)'(v);
        return sat_mag(v[DATA_W], PROD_W'(abs_v));
    endfunction

endpackage

>>> src/cau_front.sv
// Front pipeline: operand products, exact sums and the simple operations, three stages.
module cau_front #(
    parameter int FRAC_BITS = 16,
    parameter int NUM_W     = 64 + FRAC_BITS
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  en,
    input  logic                                  in_valid,
    input  logic [2:0]                            in_op,
    input  logic signed [cau_pkg::DATA_W-1:0]     a_re,
    input  logic signed [cau_pkg::DATA_W-1:0]     a_im,
    input  logic signed [cau_pkg::DATA_W-1:0]     b_re,
    input  logic signed [cau_pkg::DATA_W-1:0]     b_im,
    output logic                                  out_valid,
    output logic [NUM_W-1:0]                      out_num_re,
    output logic [NUM_W-1:0]                      out_num_im,
    output logic [cau_pkg::PROD_W-1:0]            out_den,
    output cau_pkg::side_t                        out_side
);

    localparam int SUM_W = cau_pkg::PROD_W + 2;
    localparam logic signed [cau_pkg::DATA_W:0] ONE_Q = (cau_pkg::DATA_W+1)'(1) <<< FRAC_BITS;

    // Stage 1: products.
    logic                                v1_reg;
    logic [2:0]                          op1_reg;
    logic signed [cau_pkg::DATA_W-1:0]   ar1_reg, ai1_reg, br1_reg, bi1_reg;
    logic signed [cau_pkg::PROD_W-1:0]   p_arbr_reg, p_aibi_reg, p_arbi_reg, p_aibr_reg;
    logic signed [cau_pkg::PROD_W-1:0]   p_brbr_reg, p_bibi_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            op1_reg    <= in_op;
            ar1_reg    <= a_re;
            ai1_reg    <= a_im;
            br1_reg    <= b_re;
            bi1_reg    <= b_im;
            p_arbr_reg <= a_re * b_re;
            p_aibi_reg <= a_im * b_im;
            p_arbi_reg <= a_re * b_im;
            p_aibr_reg <= a_im * b_re;
            p_brbr_reg <= b_re * b_re;
            p_bibi_reg <= b_im * b_im;
        end
    end

    // Stage 2: exact sums as sign and magnitude, simple operations.
    logic signed [SUM_W-1:0]         re_sum, im_sum, re_abs, im_abs;
    logic [cau_pkg::PROD_W-1:0]      den_next;
    cau_pkg::sat_t                   s_re, s_im;
    cau_pkg::side_t                  side2_next;

    always_comb begin
        if (op1_reg == cau_pkg::OP_DIV) begin
            re_sum = SUM_W'(p_arbr_reg) + SUM_W'(p_aibi_reg);
            im_sum = SUM_W'(p_aibr_reg) - SUM_W'(p_arbi_reg);
        end else begin
            re_sum = SUM_W'(p_arbr_reg) - SUM_W'(p_aibi_reg);
            im_sum = SUM_W'(p_arbi_reg) + SUM_W'(p_aibr_reg);
        end
        re_abs   = re_sum[SUM_W-1] ? -re_sum : re_sum;
        im_abs   = im_sum[SUM_W-1] ? -im_sum : im_sum;
        den_next = p_brbr_reg[cau_pkg::PROD_W-1:0] + p_bibi_reg[cau_pkg::PROD_W-1:0];

        side2_next        = '0;
        side2_next.op     = op1_reg;
        side2_next.re_neg = re_sum[SUM_W-1];
        side2_next.im_neg = im_sum[SUM_W-1];
        s_re = '0;
        s_im = '0;
        unique case (op1_reg)
            cau_pkg::OP_ADD: begin
                s_re = cau_pkg::sat_signed((cau_pkg::DATA_W+1)'(ar1_reg)
                                           + (cau_pkg::DATA_W+1)'(br1_reg));
                s_im = cau_pkg::sat_signed((cau_pkg::DATA_W+1)'(ai1_reg)
                                           + (cau_pkg::DATA_W+1)'(bi1_reg));
            end
            cau_pkg::OP_SUB: begin
                s_re = cau_pkg::sat_signed((cau_pkg::DATA_W+1)'(ar1_reg)
                                           - (cau_pkg::DATA_W+1)'(br1_reg));
                s_im = cau_pkg::sat_signed((cau_pkg::DATA_W+1)'(ai1_reg)
                                           - (cau_pkg::DATA_W+1)'(bi1_reg));
            end
            cau_pkg::OP_INC: begin
                s_re = cau_pkg::sat_signed((cau_pkg::DATA_W+1)'(ar1_reg) + ONE_Q);
                s_im.value = ai1_reg;
            end
            cau_pkg::OP_EQ: begin
                side2_next.eq = (ar1_reg == br1_reg) && (ai1_reg == bi1_reg);
            end
            cau_pkg::OP_DIV: begin
                side2_next.dz = (den_next == '0);
            end
            default: begin
            end
        endcase
        side2_next.rr  = s_re.value;
        side2_next.ri  = s_im.value;
        side2_next.ovf = s_re.ovf | s_im.ovf;
    end

    logic                            v2_reg;
    logic [cau_pkg::PROD_W-1:0]      re_mag2_reg, im_mag2_reg, den2_reg;
    cau_pkg::side_t                  side2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            re_mag2_reg <= re_abs[cau_pkg::PROD_W-1:0];
            im_mag2_reg <= im_abs[cau_pkg::PROD_W-1:0];
            den2_reg    <= den_next;
            side2_reg   <= side2_next;
        end
    end

    // Stage 3: product scaling and saturation, divider operands.
    cau_pkg::sat_t  m_re, m_im;
    cau_pkg::side_t side3_next;

    always_comb begin
        m_re       = cau_pkg::sat_mag(side2_reg.re_neg, re_mag2_reg >> FRAC_BITS);
        m_im       = cau_pkg::sat_mag(side2_reg.im_neg, im_mag2_reg >> FRAC_BITS);
        side3_next = side2_reg;
        if (side2_reg.op == cau_pkg::OP_MUL) begin
            side3_next.rr  = m_re.value;
            side3_next.ri  = m_im.value;
            side3_next.ovf = m_re.ovf | m_im.ovf;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid <= 1'b0;
        end else if (en) begin
            out_valid <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_num_re <= NUM_W'(re_mag2_reg) << FRAC_BITS;
            out_num_im <= NUM_W'(im_mag2_reg) << FRAC_BITS;
            out_den    <= den2_reg;
            out_side   <= side3_next;
        end
    end

endmodule

>>> src/cau_div.sv
// Pipelined restoring divider: one range check stage, then one quotient bit per stage.
module cau_div #(
    parameter int NUM_W = 80,
    parameter int DEN_W = 64,
    parameter int QUO_W = 33
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [QUO_W-1:0] quo,
    output logic             big
);

    logic [DEN_W-1:0] rem_reg [0:QUO_W-1];
    logic [QUO_W-1:0] lo_reg  [0:QUO_W-1];
    logic [DEN_W-1:0] den_reg [0:QUO_W-1];
    logic [QUO_W-1:0] q_reg   [0:QUO_W];
    logic             big_reg [0:QUO_W];

    // A quotient of 2^QUO_W or more is flagged here; it saturates downstream.
    always_ff @(posedge aclk) begin
        if (en) begin
            big_reg[0] <= DEN_W'(num[NUM_W-1:QUO_W]) >= den;
            rem_reg[0] <= DEN_W'(num[NUM_W-1:QUO_W]);
            lo_reg[0]  <= num[QUO_W-1:0];
            den_reg[0] <= den;
            q_reg[0]   <= '0;
        end
    end

    for (genvar k = 1; k <= QUO_W; k++) begin : g_stage
        logic [DEN_W:0] trial;
        logic [DEN_W:0] diff;
        logic           ge;

        assign trial = {rem_reg[k-1], lo_reg[k-1][QUO_W-k]};
        assign ge    = trial >= {1'b0, den_reg[k-1]};
        assign diff  = trial - {1'b0, den_reg[k-1]};

        always_ff @(posedge aclk) begin
            if (en) begin
                q_reg[k]   <= {q_reg[k-1][QUO_W-2:0], ge};
                big_reg[k] <= big_reg[k-1];
            end
        end

        if (k < QUO_W) begin : g_carry
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                    lo_reg[k]  <= lo_reg[k-1];
                    den_reg[k] <= den_reg[k-1];
                end
            end
        end
    end

    assign quo = q_reg[QUO_W];
    assign big = big_reg[QUO_W];

endmodule

>>> src/complex_arith_unit.sv
// Complex arithmetic unit on signed fixed-point operands: add, subtract, multiply, divide,
// equal test and real increment. Every beat gives exactly one result beat, which passes
// three front stages, 34 divider stages and the output register; a new beat may enter on
// every cycle, and all operations share the one pipeline so results leave in order. The
// latency is set by the pipelined restoring divider, which retires one quotient bit per
// stage. When the result side stalls, the whole pipeline holds and s_tready falls.
module complex_arith_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // operation[2:0], a_real[34:3], a_imag[66:35], b_real[98:67], b_imag[130:99]
    input  logic [135:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // res_real[31:0], res_imag[63:32], is_equal[64], div_by_zero[65], overflowed[66]
    output logic [71:0]  m_tdata
);

    localparam int NUM_W = cau_pkg::PROD_W + FRAC_BITS;

    logic                        en;
    logic                        f_valid;
    logic [NUM_W-1:0]            num_re, num_im;
    logic [cau_pkg::PROD_W-1:0]  den;
    cau_pkg::side_t              f_side;
    logic [cau_pkg::QUO_W-1:0]   q_re, q_im;
    logic                        big_re, big_im;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    cau_front #(.FRAC_BITS(FRAC_BITS), .NUM_W(NUM_W)) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (s_tvalid),
        .in_op      (s_tdata[2:0]),
        .a_re       (s_tdata[34:3]),
        .a_im       (s_tdata[66:35]),
        .b_re       (s_tdata[98:67]),
        .b_im       (s_tdata[130:99]),
        .out_valid  (f_valid),
        .out_num_re (num_re),
        .out_num_im (num_im),
        .out_den    (den),
        .out_side   (f_side)
    );

    cau_div #(.NUM_W(NUM_W), .DEN_W(cau_pkg::PROD_W), .QUO_W(cau_pkg::QUO_W)) u_div_re (
        .aclk (aclk),
        .en   (en),
        .num  (num_re),
        .den  (den),
        .quo  (q_re),
        .big  (big_re)
    );

    cau_div #(.NUM_W(NUM_W), .DEN_W(cau_pkg::PROD_W), .QUO_W(cau_pkg::QUO_W)) u_div_im (
        .aclk (aclk),
        .en   (en),
        .num  (num_im),
        .den  (den),
        .quo  (q_im),
        .big  (big_im)
    );

    // Valid bits and side results delayed to line up with the divider output.
    logic           vld_reg  [0:cau_pkg::DIV_LAT-1];
    cau_pkg::side_t side_reg [0:cau_pkg::DIV_LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < cau_pkg::DIV_LAT; i++) begin
                vld_reg[i] <= 1'b0;
            end
        end else if (en) begin
            vld_reg[0] <= f_valid;
            for (int i = 1; i < cau_pkg::DIV_LAT; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= f_side;
            for (int i = 1; i < cau_pkg::DIV_LAT; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    cau_pkg::side_t             last;
    cau_pkg::sat_t              d_re, d_im;
    logic [cau_pkg::PROD_W-1:0] qm_re, qm_im;
    logic [71:0]                m_tdata_next;

    assign last = side_reg[cau_pkg::DIV_LAT-1];

    always_comb begin
        // An out-of-range quotient only has to exceed the saturation limit.
        qm_re = big_re ? (cau_pkg::PROD_W'(1) << cau_pkg::QUO_W)
                       : cau_pkg::PROD_W'(q_re);
        qm_im = big_im ? (cau_pkg::PROD_W'(1) << cau_pkg::QUO_W)
                       : cau_pkg::PROD_W'(q_im);
        d_re  = cau_pkg::sat_mag(last.re_neg, qm_re);
        d_im  = cau_pkg::sat_mag(last.im_neg, qm_im);
        if (last.op == cau_pkg::OP_DIV && !last.dz) begin
            m_tdata_next = {5'd0, d_re.ovf | d_im.ovf, 1'b0, 1'b0, d_im.value, d_re.value};
        end else begin
            m_tdata_next = {5'd0, last.ovf, last.dz, last.eq, last.ri, last.rr};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid <= 1'b0;
        end else if (en) begin
            m_tvalid <= vld_reg[cau_pkg::DIV_LAT-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata <= m_tdata_next;
        end
    end

endmodule

>>> src/cau_checker.sv
// Port-level assertions for the complex arithmetic unit, bound to the top level.
module cau_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [71:0]  m_tdata
);

    // A stalled result beat holds its data.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // Input is taken exactly when the output slot is free or draining.
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output slot");

    // A zero divisor gives a zero result without overflow.
    a_dz: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[65] |-> m_tdata[63:0] == 64'd0 && !m_tdata[66] && !m_tdata[64])
        else $error("zero divisor result not clean");

    // An equal test gives a zero result without overflow.
    a_eq: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[64] |-> m_tdata[63:0] == 64'd0 && !m_tdata[66])
        else $error("equal test result not clean");

endmodule

bind complex_arith_unit cau_checker u_cau_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
